FILE: hdl/bpa_pkg.sv
// bpa_pkg: shared types and constants of the buddy page allocator
// no dependencies; used by the channel interfaces and buddy_page_allocator
`default_nettype none

package bpa_pkg;

    localparam int unsigned TOP_ORDER = 4;
    localparam logic [31:0] ALL_USED  = 32'hffff_ffff;
    localparam int unsigned MAX_COUNT = 16;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned ORDER_W = 3;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic {
        STATUS_DONE    = 1'b0,
        STATUS_NO_SPACE = 1'b1
    } status_t;

endpackage

`default_nettype wire

FILE: hdl/bpa_if.sv
// bpa_req_if / bpa_rsp_if: valid/ready channels of the buddy page allocator
// depends on bpa_pkg for field widths
`default_nettype none

interface bpa_req_if
    import bpa_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               func;
    logic [ADDR_W-1:0]  page_address;
    logic [COUNT_W-1:0] run_len;

    modport source (output valid, output func, output page_address, output run_len,
                    input ready);
    modport sink   (input valid, input func, input page_address, input run_len,
                    output ready);
endinterface

interface bpa_rsp_if
    import bpa_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] granted_page;
    logic              status;

    modport source (output valid, output granted_page, output status, input ready);
    modport sink   (input valid, input granted_page, input status, output ready);
endinterface

`default_nettype wire

FILE: hdl/buddy_page_allocator.sv
// buddy_page_allocator: five-order buddy page allocator over one bitmap memory
// depends on bpa_pkg and the channel interfaces in bpa_if.sv
//
// usage: a request beat on req carries func (0 alloc, 1 free), page_address
// and run_len; every request yields exactly one beat on rsp with
// granted_page and status (1 when no free block is large enough or
// run_len is 0 or above 16). all five order bitmaps live in one
// single-port-read memory of 31*NUM_PAGES/512 words (3968 at the
// default) with a registered read. after reset a clearing pass writes
// every word to all ones (every page used), one word a cycle; req.ready
// stays low until it ends. software seeds free memory by issuing frees.
// an alloc scans bitmap words from word 0 of the requested order and
// moves up the orders, then splits the found block down and frees the
// trimmed tail blocks; a failed scan or a bad count goes straight to the
// response. a free walks the power-of-two parts of run_len, merging each
// with free buddies. one request is in flight at a time and req.ready
// returns as the result is registered; the memory port sets the pace.
// the result sits in an output register, so a stalled rsp does not block
// the next request, only the following result.
`default_nettype none

module buddy_page_allocator
    import bpa_pkg::*;
#(
    parameter int unsigned NUM_PAGES = 65536
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bpa_req_if.sink   req,
    bpa_rsp_if.source rsp
);

    localparam int unsigned PW = $clog2(NUM_PAGES);
    localparam int unsigned WW = PW - 5;
    localparam int unsigned W0 = NUM_PAGES / 32;
    localparam int unsigned W1 = NUM_PAGES / 64;
    localparam int unsigned W2 = NUM_PAGES / 128;
    localparam int unsigned W3 = NUM_PAGES / 256;
    localparam int unsigned W4 = NUM_PAGES / 512;
    localparam int unsigned B1 = W0;
    localparam int unsigned B2 = B1 + W1;
    localparam int unsigned B3 = B2 + W2;
    localparam int unsigned B4 = B3 + W3;
    localparam int unsigned DEPTH = B4 + W4;
    localparam int unsigned AW = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_TRIM_CHK,
        ST_TRIM_WR,
        ST_FREE_NEXT,
        ST_MERGE_RD,
        ST_MERGE_CHK,
        ST_MERGE_FREE,
        ST_RESP
    } state_t;

    function automatic logic [AW-1:0] word_addr(input logic [ORDER_W-1:0] o,
                                                input logic [WW-1:0] w);
        logic [AW-1:0] b;
        case (o)
            3'd0:    b = '0;
            3'd1:    b = AW'(B1);
            3'd2:    b = AW'(B2);
            3'd3:    b = AW'(B3);
            3'd4:    b = AW'(B4);
            default: b = '0;
        endcase
        return b + AW'(w);
    endfunction

    function automatic logic [WW-1:0] last_word(input logic [ORDER_W-1:0] o);
        logic [WW-1:0] r;
        case (o)
            3'd0:    r = WW'(W0 - 1);
            3'd1:    r = WW'(W1 - 1);
            3'd2:    r = WW'(W2 - 1);
            3'd3:    r = WW'(W3 - 1);
            3'd4:    r = WW'(W4 - 1);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [ORDER_W-1:0] ceil_order(input logic [COUNT_W-1:0] c);
        logic [ORDER_W-1:0] r;
        if (c <= 5'd1)      r = 3'd0;
        else if (c <= 5'd2) r = 3'd1;
        else if (c <= 5'd4) r = 3'd2;
        else if (c <= 5'd8) r = 3'd3;
        else                r = 3'd4;
        return r;
    endfunction

    function automatic logic [ORDER_W-1:0] low_one(input logic [COUNT_W-1:0] c);
        logic [ORDER_W-1:0] r;
        r = 3'd4;
        for (int n = 3; n >= 0; n--)
        begin
            if (c[n])
                r = ORDER_W'(n);
        end
        return r;
    endfunction

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata;
    logic        mem_re;
    logic [AW-1:0] mem_raddr;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;

    state_t state_reg, state_next;
    logic               func_reg, func_next;
    logic [16:0]        addr_reg, addr_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [ORDER_W-1:0] k_reg, k_next;
    logic [ORDER_W-1:0] j_reg, j_next;
    logic [ORDER_W-1:0] kf_reg, kf_next;
    logic               fdone_reg, fdone_next;
    logic [WW-1:0]      w_reg, w_next;
    logic [PW-1:0]      i_reg, i_next;
    logic [PW-1:0]      base_reg, base_next;
    logic [COUNT_W-1:0] off_reg, off_next;
    logic [AW-1:0]      wa_reg, wa_next;
    logic [4:0]         bit_reg, bit_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_page_reg, res_page_next;
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  granted_reg, granted_next;
    logic               status_reg, status_next;

    logic [31:0]   free_bits;
    logic [4:0]    low_free;
    logic [PW-1:0] i_shift;
    logic [PW-1:0] i_flip;
    logic [ORDER_W-1:0] tj;
    logic [PW-1:0] tidx;
    logic [31:0]   fidx_wide;
    logic [31:0]   pad_page;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata <= mem[mem_raddr];
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_page = granted_reg;
    assign rsp.status       = status_reg;

    always_comb
    begin
        free_bits = ~rdata;
        low_free  = 5'd0;
        for (int n = 31; n >= 0; n--)
        begin
            if (free_bits[n])
                low_free = 5'(n);
        end
    end

    assign i_shift   = {i_reg[PW-2:0], 1'b0};
    assign i_flip    = i_reg ^ PW'(1);
    assign tj        = low_one(off_reg);
    assign tidx      = (base_reg + PW'(off_reg)) >> tj;
    assign fidx_wide = 32'(addr_reg) >> kf_reg;
    assign pad_page  = 32'(i_reg << k_reg);

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        kf_next         = kf_reg;
        fdone_next      = fdone_reg;
        w_next          = w_reg;
        i_next          = i_reg;
        base_next       = base_reg;
        off_next        = off_reg;
        wa_next         = wa_reg;
        bit_next        = bit_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        out_valid_next  = out_valid_reg;
        granted_next    = granted_reg;
        status_next     = status_reg;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        mem_we          = 1'b0;
        mem_waddr       = wa_reg;
        mem_wdata       = rdata;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = ALL_USED;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next       = req.func;
                    addr_next       = 17'(req.page_address);
                    cnt_next        = req.run_len;
                    res_page_next   = '0;
                    res_status_next = STATUS_DONE;
                    if (req.func == FUNC_FREE)
                    begin
                        kf_next    = ORDER_W'(TOP_ORDER);
                        fdone_next = 1'b0;
                        state_next = ST_FREE_NEXT;
                    end
                    else if (req.run_len == '0 ||
                             req.run_len > COUNT_W'(MAX_COUNT))
                    begin
                        res_status_next = STATUS_NO_SPACE;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        k_next     = ceil_order(req.run_len);
                        j_next     = ceil_order(req.run_len);
                        w_next     = '0;
                        mem_re     = 1'b1;
                        mem_raddr  = word_addr(ceil_order(req.run_len), '0);
                        wa_next    = mem_raddr;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (free_bits != '0)
                begin
                    i_next     = PW'({w_reg, low_free});
                    mem_we     = 1'b1;
                    mem_wdata  = rdata | (32'd1 << low_free);
                    state_next = ST_SPLIT_RD;
                end
                else if (w_reg == last_word(j_reg))
                begin
                    if (j_reg == ORDER_W'(TOP_ORDER))
                    begin
                        res_status_next = STATUS_NO_SPACE;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        j_next    = j_reg + 3'd1;
                        w_next    = '0;
                        mem_re    = 1'b1;
                        mem_raddr = word_addr(j_reg + 3'd1, '0);
                        wa_next   = mem_raddr;
                    end
                end
                else
                begin
                    w_next    = w_reg + WW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = word_addr(j_reg, w_reg + WW'(1));
                    wa_next   = mem_raddr;
                end
            end
            ST_SPLIT_RD:
            begin
                if (j_reg == k_reg)
                begin
                    base_next     = i_reg << k_reg;
                    off_next      = cnt_reg;
                    res_page_next = pad_page[ADDR_W-1:0];
                    state_next    = ST_TRIM_CHK;
                end
                else
                begin
                    j_next     = j_reg - 3'd1;
                    i_next     = i_shift;
                    bit_next   = i_shift[4:0];
                    mem_re     = 1'b1;
                    mem_raddr  = word_addr(j_reg - 3'd1, i_shift[PW-1:5]);
                    wa_next    = mem_raddr;
                    state_next = ST_SPLIT_WR;
                end
            end
            ST_SPLIT_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = (rdata | (32'd1 << bit_reg)) & ~(32'd2 << bit_reg);
                state_next = ST_SPLIT_RD;
            end
            ST_TRIM_CHK:
            begin
                if (off_reg >= (COUNT_W'(1) << k_reg))
                    state_next = ST_RESP;
                else
                begin
                    bit_next   = tidx[4:0];
                    j_next     = tj;
                    mem_re     = 1'b1;
                    mem_raddr  = word_addr(tj, tidx[PW-1:5]);
                    wa_next    = mem_raddr;
                    state_next = ST_TRIM_WR;
                end
            end
            ST_TRIM_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rdata & ~(32'd1 << bit_reg);
                off_next   = off_reg + (COUNT_W'(1) << j_reg);
                state_next = ST_TRIM_CHK;
            end
            ST_FREE_NEXT:
            begin
                if (fdone_reg)
                    state_next = ST_RESP;
                else
                begin
                    kf_next    = kf_reg - 3'd1;
                    fdone_next = (kf_reg == '0);
                    if (cnt_reg[kf_reg])
                    begin
                        addr_next = addr_reg + (17'd1 << kf_reg);
                        if (fidx_wide < (32'(NUM_PAGES) >> kf_reg))
                        begin
                            j_next     = kf_reg;
                            i_next     = fidx_wide[PW-1:0];
                            state_next = ST_MERGE_RD;
                        end
                    end
                end
            end
            ST_MERGE_RD:
            begin
                mem_re = 1'b1;
                if (j_reg < ORDER_W'(TOP_ORDER))
                begin
                    bit_next   = i_flip[4:0];
                    mem_raddr  = word_addr(j_reg, i_flip[PW-1:5]);
                    state_next = ST_MERGE_CHK;
                end
                else
                begin
                    bit_next   = i_reg[4:0];
                    mem_raddr  = word_addr(j_reg, i_reg[PW-1:5]);
                    state_next = ST_MERGE_FREE;
                end
                wa_next = mem_raddr;
            end
            ST_MERGE_CHK:
            begin
                mem_we = 1'b1;
                if (!rdata[bit_reg])
                begin
                    mem_wdata  = rdata | (32'd1 << bit_reg);
                    i_next     = i_reg >> 1;
                    j_next     = j_reg + 3'd1;
                    state_next = ST_MERGE_RD;
                end
                else
                begin
                    mem_wdata  = rdata & ~(32'd1 << (bit_reg ^ 5'd1));
                    state_next = ST_FREE_NEXT;
                end
            end
            ST_MERGE_FREE:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rdata & ~(32'd1 << bit_reg);
                state_next = ST_FREE_NEXT;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = res_page_reg;
                    status_next    = res_status_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        addr_reg       <= addr_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        j_reg          <= j_next;
        kf_reg         <= kf_next;
        fdone_reg      <= fdone_next;
        w_reg          <= w_next;
        i_reg          <= i_next;
        base_reg       <= base_next;
        off_reg        <= off_next;
        wa_reg         <= wa_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        granted_reg    <= granted_next;
        status_reg     <= status_next;
    end

    // a read and a write never hit the same word in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("bitmap read and write collide");

    // a failed allocation reports page zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status) |-> (rsp.granted_page == '0))
        else $error("failure beat with nonzero page");

    // splitting never goes below the requested order
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SPLIT_RD && func_reg == FUNC_ALLOC) |-> (j_reg >= k_reg))
        else $error("split below requested order");

    // a free never reports a granted page
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && func_reg == FUNC_FREE) |-> (res_page_reg == '0))
        else $error("free result carries a page");

endmodule

`default_nettype wire
